// File: hw/rtl/dtmf_sg_pkg.sv
package dtmf_sg_pkg;

    localparam int PHASE_FRAC_BITS = 16;

    // f * index fits 26 bits: 1633 * 32767 < 2^26
    localparam int PROD_W   = 26;
    localparam int REM_W    = 16;
    localparam int RATE_W   = 16;
    localparam int DIGIT_W  = 4;
    localparam int INDEX_W  = 15;
    localparam int SAMPLE_W = 12;
    localparam int FREQ_W   = 11;

    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 16'd8000;

    localparam logic [FREQ_W-1:0] ROW_FREQ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
    localparam logic [FREQ_W-1:0] COL_FREQ [4] = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

    // round(2*pi*2^15)
    localparam logic [17:0] TWOPI_Q15 = 18'd205887;

    // cosine polynomial coefficients, Q1.15
    localparam logic signed [16:0] C1_Q15 = 17'sd32748;
    localparam logic signed [15:0] C2_Q15 = -16'sd16239;
    localparam logic [10:0]        C3_Q15 = 11'd1206;

    localparam logic [14:0] Q15_HALF = 15'd16384;

    // 32767 * 3
    localparam logic signed [17:0] FULL_SCALE_X3 = 18'sd98301;

    // floor(q / 10) = (q * 52429) >> 19, exact for q below 98310
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [3:0] ROUND16_BIAS = 4'd8;

endpackage

// File: hw/rtl/dtmf_sample_generator_top.sv
// throughput: one item per cycle while busy is low; the phase divider is a restoring
//   divider, one remainder bit per stage over 26 + PHASE_FRAC_BITS stages, per tone
// o_valid strobes for one cycle per item; the receiver cannot stall and nothing waits
// reset: synchronous, active low; clears all valid bits, sets sample_rate to 8000,
//   busy is high during reset and low from the first cycle after it
module dtmf_sample_generator_top #(
    parameter int PHASE_FRAC_BITS = dtmf_sg_pkg::PHASE_FRAC_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [dtmf_sg_pkg::RATE_W-1:0]            i_cfg_wdata,
    input  logic                                      start,
    output logic                                      busy,
    input  logic [dtmf_sg_pkg::DIGIT_W-1:0]           i_digit,
    input  logic [dtmf_sg_pkg::INDEX_W-1:0]           i_sample_index,
    output logic                                      o_valid,
    output logic signed [dtmf_sg_pkg::SAMPLE_W-1:0]   o_sample
);

    localparam int PH_W   = PHASE_FRAC_BITS;
    localparam int PROD_W = dtmf_sg_pkg::PROD_W;
    localparam int REM_W  = dtmf_sg_pkg::REM_W;
    localparam int STEPS  = PROD_W + PH_W;
    localparam int XP_W   = PH_W + 18;

    localparam logic [PH_W-1:0] QUARTER = PH_W'(1) << (PH_W - 2);
    localparam logic [PH_W-1:0] HALF    = PH_W'(1) << (PH_W - 1);

    logic                               r_run;
    logic [dtmf_sg_pkg::RATE_W-1:0]     r_sample_rate;

    logic                               r_mul_valid;
    logic [PROD_W-1:0]                  r_mul_prod [2];

    logic                               r_dv_valid [STEPS];
    logic [REM_W-1:0]                   r_dv_rem   [STEPS-1][2];
    logic [PROD_W-1:0]                  r_dv_dvd   [PROD_W-1][2];
    logic [PH_W-1:0]                    r_dv_quo   [STEPS][2];

    logic [7:0]                         r_pv;
    logic [6:0]                         r_neg_sh [2];
    logic [PH_W-2:0]                    r_f_a    [2];
    logic [15:0]                        r_x      [2];
    logic [31:0]                        r_sq     [2];
    logic [16:0]                        r_x2     [2];
    logic [27:0]                        r_m3     [2];
    logic [16:0]                        r_x2_d   [2];
    logic signed [15:0]                 r_t      [2];
    logic [16:0]                        r_x2_dd  [2];
    logic signed [33:0]                 r_pp     [2];
    logic signed [16:0]                 r_s      [2];

    logic                               r_n_valid;
    logic signed [35:0]                 r_num;
    logic                               r_q_valid;
    logic [16:0]                        r_q;
    logic                               r_qneg;
    logic                               r_d_valid;
    logic [13:0]                        r_s16;
    logic                               r_dneg;
    logic                               r_o_valid;
    logic signed [dtmf_sg_pkg::SAMPLE_W-1:0] r_sample;

    logic signed [17:0]                 n_ssum;
    logic [35:0]                        n_mag;
    logic [32:0]                        n_qm;
    logic [14:0]                        n_rr;
    logic [11:0]                        n_r12;

    assign busy     = ~r_run;
    assign o_valid  = r_o_valid;
    assign o_sample = r_sample;

    // config, tone lookup and f * index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run         <= 1'b0;
            r_sample_rate <= dtmf_sg_pkg::SAMPLE_RATE_RST;
            r_mul_valid   <= 1'b0;
        end else begin
            r_run       <= 1'b1;
            r_mul_valid <= start & ~busy;
            if (i_cfg_we) begin
                r_sample_rate <= i_cfg_wdata;
            end
        end
        r_mul_prod[0] <= PROD_W'(dtmf_sg_pkg::ROW_FREQ[i_digit[3:2]]) * PROD_W'(i_sample_index);
        r_mul_prod[1] <= PROD_W'(dtmf_sg_pkg::COL_FREQ[i_digit[1:0]]) * PROD_W'(i_sample_index);
    end

    // restoring divider: first the remainder of f * index, then the phase quotient bits
    for (genvar k = 0; k < STEPS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (k == 0) begin
                r_dv_valid[k] <= r_mul_valid;
            end else begin
                r_dv_valid[k] <= r_dv_valid[(k == 0) ? 0 : k-1];
            end
        end

        for (genvar ln = 0; ln < 2; ln++) begin : g_ln
            logic [REM_W-1:0]  rem_in;
            logic [PROD_W-1:0] dvd_in;
            logic [PH_W-1:0]   quo_in;
            logic [REM_W:0]    trial;
            logic [REM_W:0]    diff;
            logic              q;

            if (k == 0) begin : g_src0
                assign rem_in = '0;
                assign quo_in = '0;
                assign dvd_in = r_mul_prod[ln];
            end else begin : g_src
                assign rem_in = r_dv_rem[k-1][ln];
                assign quo_in = r_dv_quo[k-1][ln];
                if (k < PROD_W) begin : g_dvd
                    assign dvd_in = r_dv_dvd[k-1][ln];
                end else begin : g_zero
                    assign dvd_in = '0;
                end
            end

            assign trial = {rem_in, dvd_in[PROD_W-1]};
            assign diff  = trial - {1'b0, r_sample_rate};
            assign q     = (trial >= {1'b0, r_sample_rate});

            always_ff @(posedge i_clk) begin
                r_dv_quo[k][ln] <= {quo_in[PH_W-2:0], q};
            end

            if (k < STEPS - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    r_dv_rem[k][ln] <= q ? diff[REM_W-1:0] : trial[REM_W-1:0];
                end
            end

            if (k < PROD_W - 1) begin : g_shift
                always_ff @(posedge i_clk) begin
                    r_dv_dvd[k][ln] <= {dvd_in[PROD_W-2:0], 1'b0};
                end
            end
        end
    end

    // per tone: quadrant fold and cosine polynomial
    for (genvar ln = 0; ln < 2; ln++) begin : g_tone
        logic [PH_W-1:0]    ph;
        logic [PH_W-1:0]    c0;
        logic [PH_W-1:0]    c1;
        logic [PH_W-1:0]    ca;
        logic               n_neg;
        logic [XP_W-1:0]    xprod;
        logic [32:0]        sqr;
        logic [28:0]        m3r;
        logic signed [34:0] ppr;
        logic signed [19:0] prnd;
        logic signed [20:0] p;
        logic signed [20:0] sine;

        assign ph    = (r_sample_rate == '0) ? '0 : r_dv_quo[STEPS-1][ln];
        assign c0    = QUARTER - ph;
        assign c1    = (c0 > HALF) ? PH_W'(0) - c0 : c0;
        assign n_neg = (c1 >= QUARTER);
        assign ca    = n_neg ? HALF - c1 : c1;

        assign xprod = XP_W'(r_f_a[ln]) * XP_W'(dtmf_sg_pkg::TWOPI_Q15) + XP_W'(HALF);
        assign sqr   = 33'(r_sq[ln]) + 33'(dtmf_sg_pkg::Q15_HALF);
        assign m3r   = 29'(r_m3[ln]) + 29'(dtmf_sg_pkg::Q15_HALF);
        assign ppr   = 35'(r_pp[ln]) + 35'($signed({1'b0, dtmf_sg_pkg::Q15_HALF}));
        assign prnd  = ppr[34:15];
        assign p     = 21'(dtmf_sg_pkg::C1_Q15) + 21'(prnd);
        assign sine  = r_neg_sh[ln][6] ? -p : p;

        always_ff @(posedge i_clk) begin
            r_neg_sh[ln] <= {r_neg_sh[ln][5:0], n_neg};
            r_f_a[ln]    <= ca[PH_W-2:0];
            r_x[ln]      <= xprod[PH_W+15:PH_W];
            r_sq[ln]     <= 32'(r_x[ln]) * 32'(r_x[ln]);
            r_x2[ln]     <= sqr[31:15];
            r_m3[ln]     <= 28'(r_x2[ln]) * 28'(dtmf_sg_pkg::C3_Q15);
            r_x2_d[ln]   <= r_x2[ln];
            r_t[ln]      <= dtmf_sg_pkg::C2_Q15 + $signed({3'b000, m3r[27:15]});
            r_x2_dd[ln]  <= r_x2_d[ln];
            r_pp[ln]     <= 34'($signed({1'b0, r_x2_dd[ln]})) * 34'(r_t[ln]);
            r_s[ln]      <= 17'(sine);
        end
    end

    // mix, scale by 3 * full scale, divide by 655360, round to 12 bits
    assign n_ssum = 18'(r_s[0]) + 18'(r_s[1]);
    assign n_mag  = r_num[35] ? 36'(-r_num) : 36'(r_num);
    assign n_qm   = 33'(r_q) * 33'(dtmf_sg_pkg::DIV10_RECIP);
    assign n_rr   = 15'(r_s16) + 15'(dtmf_sg_pkg::ROUND16_BIAS);
    assign n_r12  = {1'b0, n_rr[14:4]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= '0;
            r_n_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_pv      <= {r_pv[6:0], r_dv_valid[STEPS-1]};
            r_n_valid <= r_pv[7];
            r_q_valid <= r_n_valid;
            r_d_valid <= r_q_valid;
            r_o_valid <= r_d_valid;
        end
        r_num    <= 36'(n_ssum) * 36'(dtmf_sg_pkg::FULL_SCALE_X3);
        r_q      <= n_mag[32:16];
        r_qneg   <= r_num[35];
        r_s16    <= n_qm[dtmf_sg_pkg::DIV10_SHIFT+13:dtmf_sg_pkg::DIV10_SHIFT];
        r_dneg   <= r_qneg;
        r_sample <= r_dneg ? $signed(12'(12'd0 - n_r12)) : $signed(n_r12);
    end

endmodule

// File: test/testbench.sv
module testbench;

    localparam int FRAC_BITS = dtmf_sg_pkg::PHASE_FRAC_BITS;
    localparam int RESULT_LATENCY = FRAC_BITS + 39;
    localparam int N_KEY_ROWS = 24;
    localparam int RAND_STAGES = 10;
    localparam int ITEMS_PER_STAGE = 190;
    localparam int MAX_PRINTED = 20;

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n = 1'b0;
    logic                                    i_cfg_we = 1'b0;
    logic [dtmf_sg_pkg::RATE_W-1:0]          i_cfg_wdata = '0;
    logic                                    start = 1'b0;
    logic                                    busy;
    logic [dtmf_sg_pkg::DIGIT_W-1:0]         i_digit = '0;
    logic [dtmf_sg_pkg::INDEX_W-1:0]         i_sample_index = '0;
    logic                                    o_valid;
    logic signed [dtmf_sg_pkg::SAMPLE_W-1:0] o_sample;

    dtmf_sample_generator_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_digit        (i_digit),
        .i_sample_index (i_sample_index),
        .o_valid        (o_valid),
        .o_sample       (o_sample)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [dtmf_sg_pkg::RATE_W-1:0]   rate_hz;
        logic [dtmf_sg_pkg::DIGIT_W-1:0]  digit;
        logic [dtmf_sg_pkg::INDEX_W-1:0]  idx;
        logic                             known;
        logic [dtmf_sg_pkg::SAMPLE_W-1:0] want;
    } t_key_row;

    // known rows: index zero, zero rate and a rate of one all give a silent sample
    t_key_row key_rows [N_KEY_ROWS] = '{
        '{16'd8000,  4'd0,  15'd0,     1'b1, 12'd0},
        '{16'd8000,  4'd15, 15'd32767, 1'b0, 12'd0},
        '{16'd8000,  4'd5,  15'd1,     1'b0, 12'd0},
        '{16'd8000,  4'd10, 15'd16384, 1'b0, 12'd0},
        '{16'd8000,  4'd1,  15'd21845, 1'b0, 12'd0},
        '{16'd8000,  4'd14, 15'd10922, 1'b0, 12'd0},
        '{16'd0,     4'd7,  15'd1234,  1'b1, 12'd0},
        '{16'd0,     4'd15, 15'd32767, 1'b1, 12'd0},
        '{16'd2788,  4'd0,  15'd1,     1'b0, 12'd0},
        '{16'd2788,  4'd3,  15'd3,     1'b0, 12'd0},
        '{16'd2788,  4'd2,  15'd2,     1'b0, 12'd0},
        '{16'd4000,  4'd12, 15'd32767, 1'b0, 12'd0},
        '{16'd4000,  4'd0,  15'd1,     1'b0, 12'd0},
        '{16'd48000, 4'd15, 15'd32767, 1'b0, 12'd0},
        '{16'd48000, 4'd9,  15'd100,   1'b0, 12'd0},
        '{16'd48000, 4'd6,  15'd0,     1'b1, 12'd0},
        '{16'd65535, 4'd14, 15'd32767, 1'b0, 12'd0},
        '{16'd65535, 4'd13, 15'd12345, 1'b0, 12'd0},
        '{16'd1,     4'd4,  15'd777,   1'b1, 12'd0},
        '{16'd1,     4'd15, 15'd32767, 1'b1, 12'd0},
        '{16'd6532,  4'd3,  15'd1,     1'b0, 12'd0},
        '{16'd6532,  4'd3,  15'd3,     1'b0, 12'd0},
        '{16'd6532,  4'd8,  15'd4,     1'b0, 12'd0},
        '{16'd8000,  4'd11, 15'd0,     1'b1, 12'd0}
    };

    logic [dtmf_sg_pkg::RATE_W-1:0]          tone_rate_hz = dtmf_sg_pkg::SAMPLE_RATE_RST;
    logic signed [dtmf_sg_pkg::SAMPLE_W-1:0] pending_samples [$];
    logic signed [dtmf_sg_pkg::SAMPLE_W-1:0] want_sample;
    int mismatches = 0;
    int samples_seen = 0;
    int items_sent = 0;
    int rate_writes = 0;

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] sample check: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic longint row_hz(input logic [1:0] r);
        case (r)
            2'd0: return 697;
            2'd1: return 770;
            2'd2: return 852;
            default: return 941;
        endcase
    endfunction

    function automatic longint col_hz(input logic [1:0] c);
        case (c)
            2'd0: return 1209;
            2'd1: return 1336;
            2'd2: return 1477;
            default: return 1633;
        endcase
    endfunction

    // floor(v / 2^15 + 1/2)
    function automatic longint q15_round(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint cos_series(input longint c);
        longint x;
        longint x2;
        longint t;
        x = (c * 205887 + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        x2 = q15_round(x * x);
        t = -16239 + q15_round(1206 * x2);
        return 32748 + q15_round(x2 * t);
    endfunction

    function automatic longint sine_of_phase(input longint ph);
        longint turn;
        longint c;
        turn = longint'(1) << FRAC_BITS;
        c = ((turn >>> 2) - ph) & (turn - 1);
        if (c > (turn >>> 1)) c = turn - c;
        if (c < (turn >>> 2)) return cos_series(c);
        return -cos_series((turn >>> 1) - c);
    endfunction

    function automatic longint phase_of(
        input longint hz,
        input logic [dtmf_sg_pkg::INDEX_W-1:0] idx
    );
        longint p;
        if (tone_rate_hz == '0) return 0;
        p = (hz * longint'(idx)) % longint'(tone_rate_hz);
        return (p << FRAC_BITS) / longint'(tone_rate_hz);
    endfunction

    function automatic logic signed [dtmf_sg_pkg::SAMPLE_W-1:0] dtmf_sample_of(
        input logic [dtmf_sg_pkg::DIGIT_W-1:0] digit,
        input logic [dtmf_sg_pkg::INDEX_W-1:0] idx
    );
        longint s_lo;
        longint s_hi;
        longint num;
        longint mag;
        longint r;
        s_lo = sine_of_phase(phase_of(row_hz(digit[3:2]), idx));
        s_hi = sine_of_phase(phase_of(col_hz(digit[1:0]), idx));
        num = (s_lo + s_hi) * 98301;
        mag = (num < 0) ? -num : num;
        r = ((mag / 655360) + 8) >>> 4;
        if (num < 0) r = -r;
        return r[dtmf_sg_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic logic [dtmf_sg_pkg::RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return dtmf_sg_pkg::RATE_W'($urandom);
            3: return 16'd8000;
            4: return 16'd44100;
            5: return 16'd11025;
            6: return 16'd4000;
            7: return 16'd48000;
            default: return dtmf_sg_pkg::RATE_W'($urandom_range(4000, 48000));
        endcase
    endfunction

    task automatic send_item(
        input logic [dtmf_sg_pkg::DIGIT_W-1:0]         d,
        input logic [dtmf_sg_pkg::INDEX_W-1:0]         ix,
        input logic signed [dtmf_sg_pkg::SAMPLE_W-1:0] want
    );
        start <= 1'b1;
        i_digit <= d;
        i_sample_index <= ix;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_samples.push_back(want);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [dtmf_sg_pkg::RATE_W-1:0] hz);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= hz;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tone_rate_hz = hz;
        rate_writes++;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (o_valid === 1'b1) begin
            samples_seen++;
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("sample %0d with no item pending", o_sample));
            end else begin
                want_sample = pending_samples.pop_front();
                if (o_sample !== want_sample) begin
                    report_mismatch($sformatf("got %0d, predicted %0d", o_sample, want_sample));
                end
            end
        end
    end

    initial begin
        int row_i;
        int stage_i;
        int sent_in_stage;
        int burst_len;
        int tone_left;
        bit no_gaps;
        logic [dtmf_sg_pkg::DIGIT_W-1:0] d;
        logic [dtmf_sg_pkg::INDEX_W-1:0] ix;
        logic [dtmf_sg_pkg::DIGIT_W-1:0] tone_digit;
        logic [dtmf_sg_pkg::INDEX_W-1:0] tone_idx;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row_i = 0; row_i < N_KEY_ROWS; row_i++) begin
            if (key_rows[row_i].rate_hz != tone_rate_hz) begin
                drain();
                write_rate(key_rows[row_i].rate_hz);
            end
            d = key_rows[row_i].digit;
            ix = key_rows[row_i].idx;
            if (key_rows[row_i].known) begin
                send_item(d, ix, key_rows[row_i].want);
            end else begin
                send_item(d, ix, dtmf_sample_of(d, ix));
            end
        end

        tone_digit = '0;
        tone_idx = '0;
        for (stage_i = 0; stage_i < RAND_STAGES; stage_i++) begin
            drain();
            write_rate(pick_rate());
            no_gaps = ($urandom_range(0, 3) == 0);
            sent_in_stage = 0;
            tone_left = 0;
            while (sent_in_stage < ITEMS_PER_STAGE) begin
                burst_len = $urandom_range(1, 40);
                if (burst_len > ITEMS_PER_STAGE - sent_in_stage) begin
                    burst_len = ITEMS_PER_STAGE - sent_in_stage;
                end
                repeat (burst_len) begin
                    if (tone_left == 0) begin
                        tone_digit = dtmf_sg_pkg::DIGIT_W'($urandom_range(0, 15));
                        tone_idx = ($urandom_range(0, 3) == 0) ? '0
                                 : dtmf_sg_pkg::INDEX_W'($urandom);
                        tone_left = $urandom_range(8, 64);
                    end
                    // mostly consecutive indexes of one key, some stray items
                    if ($urandom_range(0, 3) == 0) begin
                        d = dtmf_sg_pkg::DIGIT_W'($urandom_range(0, 15));
                        ix = dtmf_sg_pkg::INDEX_W'($urandom);
                    end else begin
                        d = tone_digit;
                        ix = tone_idx;
                        tone_idx++;
                        tone_left--;
                    end
                    send_item(d, ix, dtmf_sample_of(d, ix));
                    sent_in_stage++;
                end
                if (!no_gaps && $urandom_range(0, 2) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
        end

        drain();
        repeat (RESULT_LATENCY + 10) @(posedge i_clk);

        $display("ran %0d items over %0d sample rate writes, %0d samples checked",
                 items_sent, rate_writes, samples_seen);
        $display("keys 0-15, rates zero through 65535, quarter-turn phases, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("dtmf_sample_generator_top verification clean");
        end else begin
            $display("dtmf_sample_generator_top verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        report_mismatch("timed out waiting on the block");
        $display("dtmf_sample_generator_top verification failed");
        $finish;
    end

endmodule
